### rtl/nearest_projected_point_search_core_defines.svh
`ifndef NEAREST_PROJECTED_POINT_SEARCH_CORE_DEFINES_SVH
`define NEAREST_PROJECTED_POINT_SEARCH_CORE_DEFINES_SVH

// Concurrent assertion clocked on the rising edge, held off during reset.
`define NPPS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define NPPS_ASSERT(lbl, prop, msg) \
   `NPPS_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

### rtl/npps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npps_pkg;

   localparam int CoordW  = 16;
   localparam int SurfW   = 8;
   localparam int MeshW   = 10;
   localparam int DistW   = 48;
   localparam int ProjW   = 24;
   localparam int NumW    = 34;
   localparam int RemW    = 34;
   localparam int DivW    = NumW + 8;
   localparam int RowW    = 64;
   localparam int RegIdxW = 3;

   localparam int DefMaxSurfaces = 256;
   localparam int DefMaxMeshSide = 1024;

   localparam logic [RowW-1:0] RowXReset = 64'h0000_0000_0000_1000;
   localparam logic [RowW-1:0] RowYReset = 64'h0000_0000_1000_0000;
   localparam logic [RowW-1:0] RowWReset = 64'h1000_0000_0000_0000;

   typedef enum logic [RegIdxW-1:0] {
      REG_ROW_X = 3'd0,
      REG_ROW_Y = 3'd1,
      REG_ROW_W = 3'd2,
      REG_REF_X = 3'd3,
      REG_REF_Y = 3'd4,
      REG_REF_Z = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic [SurfW-1:0]         surf;
      logic [MeshW-1:0]         u;
      logic [MeshW-1:0]         v;
      logic                     first;
      logic                     last;
      logic                     tag_ok;
   } npps_item_type;

   typedef struct packed {
      logic [RowW-1:0]          row_x;
      logic [RowW-1:0]          row_y;
      logic [RowW-1:0]          row_w;
      logic signed [CoordW-1:0] ref_x;
      logic signed [CoordW-1:0] ref_y;
      logic signed [CoordW-1:0] ref_z;
   } npps_cfg_type;

endpackage

`default_nettype wire

### rtl/npps_front.sv
`timescale 1ns / 1ps
`default_nettype none

module npps_front import npps_pkg::*; #(
   parameter int MAX_SURFACES  = DefMaxSurfaces,
   parameter int MAX_MESH_SIDE = DefMaxMeshSide
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [79:0]   req_tdata,
   input  wire logic          req_tuser,
   input  wire logic          req_tlast,
   output npps_item_type      item,
   output logic               item_valid,
   input  wire logic          item_pop
);

   npps_item_type q_mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   npps_item_type new_item;
   logic          push;

   always_comb begin
      new_item.x     = req_tdata[15:0];
      new_item.y     = req_tdata[31:16];
      new_item.z     = req_tdata[47:32];
      new_item.surf  = req_tdata[55:48];
      new_item.u     = req_tdata[65:56];
      new_item.v     = req_tdata[75:66];
      new_item.first = req_tuser;
      new_item.last  = req_tlast;
      // Points tagged outside the configured surface or mesh range never qualify.
      new_item.tag_ok = (32'(new_item.surf) < MAX_SURFACES) &&
                        (32'(new_item.u) < MAX_MESH_SIDE) &&
                        (32'(new_item.v) < MAX_MESH_SIDE);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item       = q_mem_ff[rd_ptr_ff];
   assign item_valid = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

### rtl/npps_back.sv
`timescale 1ns / 1ps
`default_nettype none

module npps_back import npps_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  npps_cfg_type       cfg,
   input  wire logic          cfg_update,
   input  npps_item_type      item,
   input  wire logic          item_valid,
   output logic               item_pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata,
   output logic               rsp_tuser
);

   typedef enum logic [3:0] {
      B_IDLE, B_MUL, B_SUM, B_SETUP, B_DIV, B_PROJ, B_SQX, B_SQY, B_CMP, B_OUT
   } state_type;

   localparam logic [DistW-1:0] DistOnes = '1;
   localparam logic signed [ProjW-1:0] ProjMax = {1'b0, {(ProjW-1){1'b1}}};
   localparam logic signed [ProjW-1:0] ProjMin = {1'b1, {(ProjW-1){1'b0}}};
   localparam logic [DivW-1:0] NegLimit = DivW'(1) << (ProjW-1);

   state_type state_ff;
   logic      ref_pend_ff;
   logic      is_ref_ff;
   logic      q_ok_ff;
   logic [1:0] row_cnt_ff;
   logic [5:0] div_cnt_ff;

   npps_item_type cur_ff;
   logic signed [CoordW-1:0] px_ff, py_ff, pz_ff;
   logic signed [2*CoordW-1:0] prod0_ff, prod1_ff, prod2_ff;
   logic signed [CoordW-1:0] c3_ff;
   logic signed [NumW-1:0] num_x_ff, num_y_ff, num_w_ff;
   logic [DivW-1:0] divr_x_ff, divr_y_ff;
   logic [RemW-1:0] rem_x_ff, rem_y_ff;
   logic [RemW-1:0] aw_ff;
   logic            neg_x_ff, neg_y_ff;
   logic signed [ProjW-1:0] ref_proj_x_ff, ref_proj_y_ff;
   logic signed [ProjW:0]   dx_ff, dy_ff;
   logic [2*ProjW+1:0]      sqx_ff, sqy_ff;

   logic [DistW-1:0] best_dist_ff;
   logic [SurfW-1:0] best_surf_ff;
   logic [MeshW-1:0] best_u_ff, best_v_ff;
   logic             have_best_ff;

   logic             rsp_valid_ff;
   logic [79:0]      rsp_data_ff;
   logic             rsp_user_ff;

   logic [RowW-1:0]          row_sel;
   logic signed [CoordW-1:0] c0, c1, c2, c3;
   logic signed [NumW-1:0]   sum_in;
   logic [NumW-1:0]          mag_x, mag_y, mag_w;
   logic [RemW:0]            sh_x, sh_y;
   logic                     ge_x, ge_y;
   logic signed [ProjW-1:0]  proj_x, proj_y;
   logic [2*ProjW+2:0]       dist_sum;
   logic [DistW-1:0]         dist_in;
   logic [DistW-1:0]         best_eff;
   logic                     have_eff, win;

   function automatic logic signed [ProjW-1:0] sat_proj(logic [DivW-1:0] q, logic neg);
      logic signed [ProjW-1:0] r;
      if (neg) begin
         r = (q > NegLimit) ? ProjMin : -ProjW'(q);
      end else begin
         r = (q > DivW'(ProjMax)) ? ProjMax : ProjW'(q);
      end
      return r;
   endfunction

   always_comb begin
      case (row_cnt_ff)
         2'd0:    row_sel = cfg.row_x;
         2'd1:    row_sel = cfg.row_y;
         default: row_sel = cfg.row_w;
      endcase
      c0 = row_sel[15:0];
      c1 = row_sel[31:16];
      c2 = row_sel[47:32];
      c3 = row_sel[63:48];
      sum_in = NumW'(prod0_ff) + NumW'(prod1_ff) + NumW'(prod2_ff) + NumW'(c3_ff);

      mag_x = num_x_ff[NumW-1] ? NumW'(-num_x_ff) : NumW'(num_x_ff);
      mag_y = num_y_ff[NumW-1] ? NumW'(-num_y_ff) : NumW'(num_y_ff);
      mag_w = num_w_ff[NumW-1] ? NumW'(-num_w_ff) : NumW'(num_w_ff);

      // Restoring division, one quotient bit per cycle for each coordinate.
      sh_x = {rem_x_ff, divr_x_ff[DivW-1]};
      sh_y = {rem_y_ff, divr_y_ff[DivW-1]};
      ge_x = sh_x >= {1'b0, aw_ff};
      ge_y = sh_y >= {1'b0, aw_ff};

      proj_x = sat_proj(divr_x_ff, neg_x_ff);
      proj_y = sat_proj(divr_y_ff, neg_y_ff);

      dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      dist_in  = (|dist_sum[2*ProjW+2:DistW]) ? DistOnes : dist_sum[DistW-1:0];

      have_eff = cur_ff.first ? 1'b0 : have_best_ff;
      best_eff = cur_ff.first ? DistOnes : best_dist_ff;
      win      = q_ok_ff && (!have_eff || (dist_in < best_eff));
   end

   assign item_pop   = (state_ff == B_IDLE) && !ref_pend_ff && item_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         ref_pend_ff   <= 1'b0;
         is_ref_ff     <= 1'b0;
         q_ok_ff       <= 1'b0;
         row_cnt_ff    <= 2'd0;
         div_cnt_ff    <= 6'd0;
         ref_proj_x_ff <= '0;
         ref_proj_y_ff <= '0;
         best_dist_ff  <= DistOnes;
         best_surf_ff  <= '0;
         best_u_ff     <= '0;
         best_v_ff     <= '0;
         have_best_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != B_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         // A write that lands while the reference is being started keeps the request pending.
         if (cfg_update) begin
            ref_pend_ff <= 1'b1;
         end else if (state_ff == B_IDLE) begin
            ref_pend_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               row_cnt_ff <= 2'd0;
               if (ref_pend_ff) begin
                  is_ref_ff   <= 1'b1;
                  px_ff       <= cfg.ref_x;
                  py_ff       <= cfg.ref_y;
                  pz_ff       <= cfg.ref_z;
                  state_ff    <= B_MUL;
               end else if (item_valid) begin
                  is_ref_ff <= 1'b0;
                  cur_ff    <= item;
                  px_ff     <= item.x;
                  py_ff     <= item.y;
                  pz_ff     <= item.z;
                  state_ff  <= B_MUL;
               end
            end
            B_MUL: begin
               prod0_ff <= c0 * px_ff;
               prod1_ff <= c1 * py_ff;
               prod2_ff <= c2 * pz_ff;
               c3_ff    <= c3;
               state_ff <= B_SUM;
            end
            B_SUM: begin
               case (row_cnt_ff)
                  2'd0:    num_x_ff <= sum_in;
                  2'd1:    num_y_ff <= sum_in;
                  default: num_w_ff <= sum_in;
               endcase
               row_cnt_ff <= row_cnt_ff + 2'd1;
               state_ff   <= (row_cnt_ff == 2'd2) ? B_SETUP : B_MUL;
            end
            B_SETUP: begin
               divr_x_ff  <= {mag_x, 8'd0};
               divr_y_ff  <= {mag_y, 8'd0};
               rem_x_ff   <= '0;
               rem_y_ff   <= '0;
               aw_ff      <= RemW'(mag_w);
               neg_x_ff   <= num_x_ff[NumW-1] ^ num_w_ff[NumW-1];
               neg_y_ff   <= num_y_ff[NumW-1] ^ num_w_ff[NumW-1];
               div_cnt_ff <= 6'(DivW - 1);
               if (num_w_ff == '0) begin
                  // Zero w: the reference projects to the origin, a point is skipped.
                  if (is_ref_ff) begin
                     ref_proj_x_ff <= '0;
                     ref_proj_y_ff <= '0;
                     state_ff      <= B_IDLE;
                  end else begin
                     q_ok_ff  <= 1'b0;
                     state_ff <= B_CMP;
                  end
               end else if (!is_ref_ff && !cur_ff.tag_ok) begin
                  q_ok_ff  <= 1'b0;
                  state_ff <= B_CMP;
               end else begin
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               rem_x_ff   <= ge_x ? RemW'(sh_x - {1'b0, aw_ff}) : RemW'(sh_x);
               rem_y_ff   <= ge_y ? RemW'(sh_y - {1'b0, aw_ff}) : RemW'(sh_y);
               divr_x_ff  <= {divr_x_ff[DivW-2:0], ge_x};
               divr_y_ff  <= {divr_y_ff[DivW-2:0], ge_y};
               div_cnt_ff <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd0) begin
                  state_ff <= B_PROJ;
               end
            end
            B_PROJ: begin
               if (is_ref_ff) begin
                  ref_proj_x_ff <= proj_x;
                  ref_proj_y_ff <= proj_y;
                  state_ff      <= B_IDLE;
               end else begin
                  dx_ff    <= (ProjW+1)'(proj_x) - (ProjW+1)'(ref_proj_x_ff);
                  dy_ff    <= (ProjW+1)'(proj_y) - (ProjW+1)'(ref_proj_y_ff);
                  state_ff <= B_SQX;
               end
            end
            B_SQX: begin
               sqx_ff   <= (2*ProjW+2)'(dx_ff * dx_ff);
               state_ff <= B_SQY;
            end
            B_SQY: begin
               sqy_ff   <= (2*ProjW+2)'(dy_ff * dy_ff);
               q_ok_ff  <= 1'b1;
               state_ff <= B_CMP;
            end
            B_CMP: begin
               if (win) begin
                  best_dist_ff <= dist_in;
                  best_surf_ff <= cur_ff.surf;
                  best_u_ff    <= cur_ff.u;
                  best_v_ff    <= cur_ff.v;
                  have_best_ff <= 1'b1;
               end else if (cur_ff.first) begin
                  best_dist_ff <= DistOnes;
                  best_surf_ff <= '0;
                  best_u_ff    <= '0;
                  best_v_ff    <= '0;
                  have_best_ff <= 1'b0;
               end
               state_ff <= cur_ff.last ? B_OUT : B_IDLE;
            end
            B_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= have_best_ff;
                  rsp_data_ff  <= {4'd0, best_dist_ff, best_v_ff, best_u_ff, best_surf_ff};
                  best_dist_ff <= DistOnes;
                  best_surf_ff <= '0;
                  best_u_ff    <= '0;
                  best_v_ff    <= '0;
                  have_best_ff <= 1'b0;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/nearest_projected_point_search_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake           Payload
// req_      in   tvalid/tready       tdata point, tuser first_point, tlast last_point
// rsp_      out  tvalid/tready       tdata winner, tuser found
// csr_      in   we (no wait)        index, 64-bit wdata
//
// A qualifying point passes through the 42-step restoring divider that forms X
// and Y side by side; a skipped point bypasses it. A register write recomputes
// the reference projection; points wait in the two-word queue meanwhile. A
// stalled result holds the back end only on the next last point. Reset is
// synchronous and restores identity rows.

module nearest_projected_point_search_core import npps_pkg::*; #(
   parameter int MAX_SURFACES  = DefMaxSurfaces,
   parameter int MAX_MESH_SIDE = DefMaxMeshSide
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [79:0]         req_tdata,  // point_x, point_y, point_z, surface_index,
                                                // u_index, v_index, zero fill
   input  wire logic                req_tuser,  // first_point
   input  wire logic                req_tlast,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [79:0]              rsp_tdata,  // best_surface, best_u, best_v,
                                                // best_dist_sq, zero fill
   output logic                     rsp_tuser,  // found
   input  wire logic                csr_we,
   input  wire logic [RegIdxW-1:0]  csr_index,
   input  wire logic [RowW-1:0]     csr_wdata
);

   npps_cfg_type  cfg_ff;
   npps_item_type item;
   logic          item_valid;
   logic          item_pop;
   logic          cfg_update;

   assign cfg_update = csr_we && (csr_index inside {[REG_ROW_X:REG_REF_Z]});

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_x <= RowXReset;
         cfg_ff.row_y <= RowYReset;
         cfg_ff.row_w <= RowWReset;
         cfg_ff.ref_x <= '0;
         cfg_ff.ref_y <= '0;
         cfg_ff.ref_z <= '0;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_ROW_X: cfg_ff.row_x <= csr_wdata;
            REG_ROW_Y: cfg_ff.row_y <= csr_wdata;
            REG_ROW_W: cfg_ff.row_w <= csr_wdata;
            REG_REF_X: cfg_ff.ref_x <= csr_wdata[CoordW-1:0];
            REG_REF_Y: cfg_ff.ref_y <= csr_wdata[CoordW-1:0];
            REG_REF_Z: cfg_ff.ref_z <= csr_wdata[CoordW-1:0];
            default: ;
         endcase
      end
   end

   npps_front #(
      .MAX_SURFACES  (MAX_SURFACES),
      .MAX_MESH_SIDE (MAX_MESH_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   npps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cfg_update (cfg_update),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/npps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_projected_point_search_core_defines.svh"

module npps_checker import npps_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic [79:0]        req_tdata,
   input wire logic               req_tuser,
   input wire logic               req_tlast,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [79:0]        rsp_tdata,
   input wire logic               rsp_tuser,
   input wire logic               csr_we,
   input wire logic [RegIdxW-1:0] csr_index,
   input wire logic [RowW-1:0]    csr_wdata
);

   // A stalled result word keeps its contents.
   `NPPS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // A failed search reports zero tags and an all-ones distance.
   `NPPS_ASSERT(a_not_found, rsp_tvalid && !rsp_tuser |-> rsp_tdata[27:0] == 28'd0 && rsp_tdata[75:28] == {48{1'b1}}, "failed search carries stale tags")

   `NPPS_ASSERT(a_pad_zero, rsp_tvalid |-> rsp_tdata[79:76] == 4'd0, "result fill bits not zero")

   // The back end needs many cycles, so a result never follows its last word at once.
   `NPPS_ASSERT(a_no_instant, $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready && req_tlast), "result appeared one cycle after last word")

endmodule

bind nearest_projected_point_search_core npps_checker u_npps_checker (.*);

`default_nettype wire

### bench/nearest_projected_point_search_core_tb.sv
`timescale 1ns / 1ps

module nearest_projected_point_search_core_tb;
   import npps_pkg::*;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic [7:0]         surf;
      logic [9:0]         u, v;
      logic               first, last;
   } point_t;

   typedef struct {
      logic        found;
      logic [7:0]  surf;
      logic [9:0]  u, v;
      logic [47:0] dist_sq;
   } winner_t;

   localparam longint DistOnes = 64'hFFFF_FFFF_FFFF;

   class nearest_point_board;
      logic [63:0] row_x, row_y, row_w;
      logic signed [15:0] ref_x, ref_y, ref_z;
      longint ref_px, ref_py;
      longint unsigned best_dist;
      logic [7:0] best_surf;
      logic [9:0] best_u, best_v;
      bit have_best;
      winner_t winners_due[$];
      int errors;

      function new();
         row_x = RowXReset;
         row_y = RowYReset;
         row_w = RowWReset;
         ref_x = 0;
         ref_y = 0;
         ref_z = 0;
         errors = 0;
         clear_best();
         project_ref();
      endfunction

      function void clear_best();
         best_dist = DistOnes;
         best_surf = 0;
         best_u = 0;
         best_v = 0;
         have_best = 0;
      endfunction

      function longint coef(logic [63:0] row, int k);
         logic signed [15:0] c;
         c = row[16*k +: 16];
         return longint'(c);
      endfunction

      function longint dot(logic [63:0] row, longint x, longint y, longint z);
         return coef(row, 0) * x + coef(row, 1) * y + coef(row, 2) * z + coef(row, 3);
      endfunction

      // Quotient of magnitudes truncated toward zero, then saturated to Q16.8.
      function longint divide_q8(longint num, longint w);
         bit neg;
         longint unsigned an, aw, q;
         neg = (num < 0) != (w < 0);
         an = longint'(num < 0 ? -num : num) << 8;
         aw = w < 0 ? -w : w;
         q = an / aw;
         if (neg)
            return q > 64'd8388608 ? -64'sd8388608 : -longint'(q);
         return q > 64'd8388607 ? 64'sd8388607 : longint'(q);
      endfunction

      function void project_ref();
         longint w;
         w = dot(row_w, ref_x, ref_y, ref_z);
         if (w == 0) begin
            ref_px = 0;
            ref_py = 0;
         end else begin
            ref_px = divide_q8(dot(row_x, ref_x, ref_y, ref_z), w);
            ref_py = divide_q8(dot(row_y, ref_x, ref_y, ref_z), w);
         end
      endfunction

      function void set_reg(reg_idx_type idx, logic [63:0] val);
         case (idx)
            REG_ROW_X: row_x = val;
            REG_ROW_Y: row_y = val;
            REG_ROW_W: row_w = val;
            REG_REF_X: ref_x = val[15:0];
            REG_REF_Y: ref_y = val[15:0];
            REG_REF_Z: ref_z = val[15:0];
            default: ;
         endcase
         project_ref();
      endfunction

      function void note_point(point_t p);
         longint w, dx, dy;
         longint unsigned d;
         winner_t r;
         if (p.first)
            clear_best();
         w = dot(row_w, p.x, p.y, p.z);
         if (w != 0) begin
            dx = divide_q8(dot(row_x, p.x, p.y, p.z), w) - ref_px;
            dy = divide_q8(dot(row_y, p.x, p.y, p.z), w) - ref_py;
            d = longint'(dx * dx) + longint'(dy * dy);
            if (d > DistOnes)
               d = DistOnes;
            if (!have_best || d < best_dist) begin
               best_dist = d;
               best_surf = p.surf;
               best_u = p.u;
               best_v = p.v;
               have_best = 1;
            end
         end
         if (p.last) begin
            r.found = have_best;
            r.surf = best_surf;
            r.u = best_u;
            r.v = best_v;
            r.dist_sq = best_dist[47:0];
            winners_due.push_back(r);
            clear_best();
         end
      endfunction

      function void check_winner(winner_t got);
         winner_t e;
         if (winners_due.size() == 0) begin
            $error("unexpected result word");
            errors++;
            return;
         end
         e = winners_due.pop_front();
         if (got.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, got.found);
            errors++;
         end
         if (got.surf !== e.surf) begin
            $error("best_surface: expected %0d, got %0d", e.surf, got.surf);
            errors++;
         end
         if (got.u !== e.u) begin
            $error("best_u: expected %0d, got %0d", e.u, got.u);
            errors++;
         end
         if (got.v !== e.v) begin
            $error("best_v: expected %0d, got %0d", e.v, got.v);
            errors++;
         end
         if (got.dist_sq !== e.dist_sq) begin
            $error("best_dist_sq: expected %0h, got %0h", e.dist_sq, got.dist_sq);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic req_tuser = 0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [RegIdxW-1:0] csr_index = '0;
   logic [RowW-1:0] csr_wdata = '0;

   nearest_point_board board = new();
   bit no_idle = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   point_t prev_point;

   nearest_projected_point_search_core dut (.*);

   always #5 clock = ~clock;

   // Receiver with random stalls.
   always @(posedge clock) begin
      winner_t got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tuser;
            got.surf = rsp_tdata[7:0];
            got.u = rsp_tdata[17:8];
            got.v = rsp_tdata[27:18];
            got.dist_sq = rsp_tdata[75:28];
            board.check_winner(got);
            stall_left = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (stall_left > 0) begin
            rsp_tready <= 0;
            stall_left--;
         end else
            rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 6000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(reg_idx_type idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      board.set_reg(idx, val);
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic send_point(point_t p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'b0, p.v, p.u, p.surf, p.z, p.y, p.x};
      req_tuser <= p.first;
      req_tlast <= p.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_point(p);
      prev_point = p;
   endtask

   // Lets every result come out and the back end drain before a register write.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.winners_due.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic logic [15:0] coord(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 32) - 16);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'hFFFF;
               default: return 16'h0000;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic point_t rand_point();
      point_t p;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 7)
         p = prev_point;
      else begin
         p.x = coord(mode < 4 ? 2 : (mode == 8 ? 1 : 0));
         p.y = coord(mode < 4 ? 2 : (mode == 8 ? 1 : 0));
         p.z = mode == 9 ? 16'h0 : coord(mode < 4 ? 2 : (mode == 8 ? 1 : 0));
      end
      p.surf = $urandom;
      p.u = $urandom;
      p.v = $urandom;
      return p;
   endfunction

   function automatic logic [63:0] rand_row(int kind);
      logic [63:0] r;
      case (kind)
         0: r = {4{16'hFFFF}};
         1: r = {4{16'h8000}};
         2: r = {4{16'h7FFF}};
         3: r = '0;
         4: for (int k = 0; k < 4; k++) r[16*k +: 16] = 16'($urandom_range(0, 8192) - 4096);
         default: r = {$urandom, $urandom};
      endcase
      return r;
   endfunction

   task automatic send_sets(int n_items);
      int sent, len;
      point_t p;
      bit noisy;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 12);
         noisy = $urandom_range(0, 9) == 0;
         for (int i = 0; i < len; i++) begin
            p = rand_point();
            p.first = noisy ? $urandom_range(0, 1) : (i == 0);
            p.last = noisy ? $urandom_range(0, 1) : (i == len - 1);
            if (sent + 1 >= n_items && i == len - 1)
               p.last = 1;
            send_point(p);
            sent++;
         end
      end
   endtask

   initial begin
      point_t p;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed part under the reset matrix: field extremes, a lone point,
      // a tie where the earlier point must win, and a run with no first flag.
      p = '{x: 16'h8000, y: 16'h7FFF, z: 16'h8000, surf: 8'hFF, u: 10'h3FF, v: 10'h3FF,
            first: 1, last: 0};
      send_point(p);
      p = '{x: 16'h7FFF, y: 16'h8000, z: 16'h7FFF, surf: 8'h00, u: 10'h000, v: 10'h000,
            first: 0, last: 1};
      send_point(p);
      p = '{x: 3, y: -4, z: 0, surf: 1, u: 2, v: 3, first: 1, last: 1};
      send_point(p);
      p = '{x: 5, y: 5, z: 9, surf: 7, u: 8, v: 9, first: 1, last: 0};
      send_point(p);
      p.surf = 8'hAA;
      p.u = 10'h155;
      p.v = 10'h2AA;
      p.last = 1;
      send_point(p);
      p = '{x: -1, y: 0, z: 0, surf: 4, u: 5, v: 6, first: 0, last: 1};
      send_point(p);
      drain();

      // Homogeneous w taken from z alone: the reference at z=0 has zero w,
      // and points with z=0 are skipped, so an all-skipped set finds nothing.
      write_reg(REG_ROW_W, 64'h0000_1000_0000_0000);
      p = '{x: 9, y: 9, z: 0, surf: 1, u: 1, v: 1, first: 1, last: 0};
      send_point(p);
      p.x = -9;
      p.last = 1;
      send_point(p);
      p = '{x: 2, y: 3, z: 0, surf: 3, u: 3, v: 3, first: 1, last: 0};
      send_point(p);
      p = '{x: 2, y: 3, z: 1, surf: 4, u: 4, v: 4, first: 0, last: 1};
      send_point(p);
      // Extreme points; the rows below saturate projection and distance.
      p = '{x: 16'h7FFF, y: 16'h7FFF, z: 1, surf: 5, u: 5, v: 5, first: 1, last: 0};
      send_point(p);
      p = '{x: 16'h8000, y: 16'h8000, z: 1, surf: 6, u: 6, v: 6, first: 0, last: 1};
      send_point(p);
      drain();
      write_reg(REG_ROW_X, 64'h0000_0000_0000_7FFF);
      write_reg(REG_ROW_Y, 64'h0000_0000_7FFF_0000);
      write_reg(REG_REF_X, 64'h8000);
      write_reg(REG_REF_Y, 64'h7FFF);
      write_reg(REG_REF_Z, 64'h0001);
      p = '{x: 16'h7FFF, y: 16'h8000, z: 1, surf: 9, u: 9, v: 9, first: 1, last: 1};
      send_point(p);
      drain();

      // Random phases, each under its own setting.
      for (int ph = 0; ph < 11; ph++) begin
         no_idle = (ph % 4) == 3;
         write_reg(REG_ROW_X, rand_row(ph < 4 ? ph : $urandom_range(4, 5)));
         write_reg(REG_ROW_Y, rand_row(ph < 4 ? 3 - ph : $urandom_range(4, 5)));
         write_reg(REG_ROW_W, ph == 5 ? 64'h1000_0000_0000_0000
                              : rand_row(ph < 4 ? ph : $urandom_range(4, 5)));
         write_reg(REG_REF_X, ph == 0 ? 64'h8000 : ph == 1 ? 64'h7FFF : 64'($urandom));
         write_reg(REG_REF_Y, ph == 0 ? 64'h7FFF : ph == 1 ? 64'h8000 : 64'($urandom));
         write_reg(REG_REF_Z, ph == 2 ? 64'h0 : 64'($urandom_range(0, 40) - 20));
         send_sets(150);
         drain();
      end

      if (board.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/npps_pkg.sv
rtl/npps_front.sv
rtl/npps_back.sv
rtl/nearest_projected_point_search_core.sv
rtl/npps_checker.sv
bench/nearest_projected_point_search_core_tb.sv
